// ===== rtl/core/first_fit_heap_allocator_top_macros.svh =====
// assertion macros for the first-fit heap allocator
// used by files that carry concurrent assertions
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define FFHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ffha_pkg.sv =====
// package for the first-fit heap allocator
// types, constants and state codes shared by all modules
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int MaxSegments = 64;
    localparam int HeaderBytes = 40;
    localparam int AddrBits    = 24;
    localparam int DataBits    = 24;
    localparam int CountBits   = 7;
    localparam logic [23:0] PoolReset = 24'd2097152;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_FND  = 2'd3
    } t_status;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [23:0] request_size;
        logic [23:0] release_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] granted_address;
        logic [6:0]  busy_count;
    } t_out_item;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SPLIT,
        S_REL_NEXT,
        S_MERGE_NEXT,
        S_REL_PREV,
        S_MERGE_PREV,
        S_SHIFT_DOWN,
        S_DONE
    } t_state;

    // control from sequencer to the table datapath
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_busy;
    } t_tbl_ctl;

endpackage

// ===== rtl/core/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator with coalescing.
// Channels: input items (command, request_size, release_address) on i_in_valid /
// o_in_stall; result items (status, granted_address, busy_count) on o_out_valid /
// i_out_stall; pool_size written on i_cfg_valid / o_cfg_ready while idle.
// One item is worked at a time. An allocate scans the segment table entry by
// entry through the registered memory read, then shifts the entries above the
// hit up one slot, then writes the split.
// A release scans the same way, checks both neighbours and shifts the tail down
// over removed entries. The single registered table read port serves every read.
// Reset and every pool_size write set up one free segment.
// The result stays in an output register while the receiver stalls; no new
// item is taken until it has left.
// Depends on ffha_pkg, ffha_table and ffha_ctrl.
`timescale 1ns / 1ps

module first_fit_heap_allocator_top #(
    parameter int MAX_SEGMENTS = ffha_pkg::MaxSegments,
    parameter int HEADER_BYTES = ffha_pkg::HeaderBytes,
    parameter int ADDR_BITS    = ffha_pkg::AddrBits
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [23:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ffha_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ffha_pkg::t_out_item  o_out_item
);
    import ffha_pkg::*;

    localparam int IdxBits = $clog2(MAX_SEGMENTS);

    logic                 w_wr_en, w_wr_busy, w_rd_busy;
    logic [IdxBits-1:0]   w_wr_idx, w_rd_idx;
    logic [ADDR_BITS-1:0] w_wr_start, w_wr_len, w_rd_start, w_rd_len;

    ffha_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .HEADER_BYTES (HEADER_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .i_in_valid, .o_in_stall, .i_in_item, .o_out_valid, .i_out_stall, .o_out_item,
        .o_wr_en (w_wr_en), .o_wr_idx (w_wr_idx), .o_wr_start (w_wr_start),
        .o_wr_len (w_wr_len), .o_wr_busy (w_wr_busy), .o_rd_idx (w_rd_idx),
        .i_rd_start (w_rd_start), .i_rd_len (w_rd_len), .i_rd_busy (w_rd_busy)
    );

    ffha_table #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_table (
        .i_clk,
        .i_wr_en (w_wr_en), .i_wr_idx (w_wr_idx), .i_wr_start (w_wr_start),
        .i_wr_len (w_wr_len), .i_wr_busy (w_wr_busy), .i_rd_idx (w_rd_idx),
        .o_rd_start (w_rd_start), .o_rd_len (w_rd_len), .o_rd_busy (w_rd_busy)
    );

endmodule

// ===== rtl/core/ffha_table.sv =====
// segment table memory: start, length and busy per entry
// one write port and one registered read port, uses ffha_pkg
`timescale 1ns / 1ps

module ffha_table #(
    parameter int MAX_SEGMENTS = ffha_pkg::MaxSegments,
    parameter int ADDR_BITS    = ffha_pkg::AddrBits,
    parameter int IDX_BITS     = $clog2(MAX_SEGMENTS)
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [IDX_BITS-1:0]   i_wr_idx,
    input  logic [ADDR_BITS-1:0]  i_wr_start,
    input  logic [ADDR_BITS-1:0]  i_wr_len,
    input  logic                  i_wr_busy,
    input  logic [IDX_BITS-1:0]   i_rd_idx,
    output logic [ADDR_BITS-1:0]  o_rd_start,
    output logic [ADDR_BITS-1:0]  o_rd_len,
    output logic                  o_rd_busy
);
    import ffha_pkg::*;

    logic [2*ADDR_BITS:0] r_mem [MAX_SEGMENTS];
    logic [2*ADDR_BITS:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_wr_busy, i_wr_start, i_wr_len};
        end
        r_rd <= r_mem[i_rd_idx];
    end

    assign o_rd_busy  = r_rd[2*ADDR_BITS];
    assign o_rd_start = r_rd[2*ADDR_BITS-1:ADDR_BITS];
    assign o_rd_len   = r_rd[ADDR_BITS-1:0];

endmodule

// ===== rtl/core/ffha_ctrl.sv =====
// sequencer of the allocator: scans, shifts and merges over the table
// drives ffha_table one entry per access, uses ffha_pkg and the macro header
`timescale 1ns / 1ps

`include "first_fit_heap_allocator_top_macros.svh"

module ffha_ctrl #(
    parameter int MAX_SEGMENTS = ffha_pkg::MaxSegments,
    parameter int HEADER_BYTES = ffha_pkg::HeaderBytes,
    parameter int ADDR_BITS    = ffha_pkg::AddrBits,
    parameter int IDX_BITS     = $clog2(MAX_SEGMENTS),
    parameter int CNT_BITS     = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [23:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ffha_pkg::t_in_item     i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ffha_pkg::t_out_item    o_out_item,
    output logic                   o_wr_en,
    output logic [IDX_BITS-1:0]    o_wr_idx,
    output logic [ADDR_BITS-1:0]   o_wr_start,
    output logic [ADDR_BITS-1:0]   o_wr_len,
    output logic                   o_wr_busy,
    output logic [IDX_BITS-1:0]    o_rd_idx,
    input  logic [ADDR_BITS-1:0]   i_rd_start,
    input  logic [ADDR_BITS-1:0]   i_rd_len,
    input  logic                   i_rd_busy
);
    import ffha_pkg::*;

    localparam logic [ADDR_BITS-1:0] Hdr = ADDR_BITS'(HEADER_BYTES);

    t_state r_state, n_state;
    t_state n_next_state;
    logic [23:0]          r_pool;
    logic [CNT_BITS-1:0]  r_seg_total, n_seg_total;
    logic [CNT_BITS-1:0]  r_busy_total, n_busy_total;
    logic [CNT_BITS-1:0]  r_idx, n_idx;      // entry being worked on
    logic [CNT_BITS-1:0]  r_hit, n_hit;      // found entry
    logic                 r_rd_wait, n_rd_wait;
    logic                 r_cmd, n_cmd;
    logic [ADDR_BITS-1:0] r_key, n_key;      // need or release address
    logic                 r_key_c, n_key_c;  // need overflows the address width
    logic [ADDR_BITS-1:0] r_req, n_req;
    logic [ADDR_BITS-1:0] r_s_start, n_s_start;  // saved entry fields
    logic [ADDR_BITS-1:0] r_s_len, n_s_len;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    // datapath adders and compares; w_sum is shared by both merge steps
    logic [ADDR_BITS-1:0] w_sum;
    logic [ADDR_BITS:0]   w_need_wide;
    logic [ADDR_BITS-1:0] w_pool_len;
    logic                 w_done_free;

    assign w_need_wide = {1'b0, ADDR_BITS'(i_in_item.request_size)} + (ADDR_BITS+1)'(HEADER_BYTES);
    assign w_pool_len  = (r_pool >= 24'(HEADER_BYTES)) ? ADDR_BITS'(r_pool - 24'(HEADER_BYTES))
                                                      : '0;
    assign w_sum       = r_s_len + i_rd_len + Hdr;
    assign w_done_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= PoolReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pool <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:       n_state = S_IDLE;
            S_IDLE: begin
                if (i_cfg_valid)                       n_state = S_INIT;
                else if (i_in_valid && !r_out_valid)   n_state = S_SCAN;
            end
            S_SCAN, S_SHIFT_UP, S_SPLIT, S_REL_NEXT, S_MERGE_NEXT,
            S_REL_PREV, S_MERGE_PREV, S_SHIFT_DOWN: n_state = r_state;
            S_DONE:       if (w_done_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
        // data-dependent transitions are set in the output block
    end

    // outputs and datapath
    always_comb begin
        t_state s_nx;
        s_nx         = n_state;
        n_seg_total  = r_seg_total;
        n_busy_total = r_busy_total;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_rd_wait    = 1'b0;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_key_c      = r_key_c;
        n_req        = r_req;
        n_s_start    = r_s_start;
        n_s_len      = r_s_len;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        o_wr_en      = 1'b0;
        o_wr_idx     = r_idx[IDX_BITS-1:0];
        o_wr_start   = '0;
        o_wr_len     = '0;
        o_wr_busy    = 1'b0;
        o_rd_idx     = r_idx[IDX_BITS-1:0];
        o_in_stall   = 1'b1;
        o_cfg_ready  = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_wr_en      = 1'b1;
                o_wr_idx     = '0;
                o_wr_len     = w_pool_len;
                n_seg_total  = CNT_BITS'(1);
                n_busy_total = '0;
            end
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                // the result register must be empty before a new item comes in
                o_in_stall  = i_cfg_valid || r_out_valid;
                n_idx       = '0;
                n_rd_wait   = 1'b1;
                n_cmd       = i_in_item.command;
                n_req       = ADDR_BITS'(i_in_item.request_size);
                n_key       = (i_in_item.command == CMD_ALLOC) ?
                              ADDR_BITS'(w_need_wide) : ADDR_BITS'(i_in_item.release_address);
                n_key_c     = (i_in_item.command == CMD_ALLOC) && w_need_wide[ADDR_BITS];
                o_rd_idx    = '0;
            end
            S_SCAN: begin
                o_rd_idx  = r_idx[IDX_BITS-1:0];
                n_rd_wait = 1'b0;
                if (r_idx >= r_seg_total) begin
                    n_out.status          = (r_cmd == CMD_ALLOC) ? ST_NO_FIT : ST_NOT_FND;
                    n_out.granted_address = '0;
                    n_out.busy_count      = 7'(r_busy_total);
                    s_nx = S_DONE;
                end else if (r_rd_wait) begin
                    s_nx = S_SCAN;
                end else if (r_cmd == CMD_ALLOC && !i_rd_busy && i_rd_len >= r_key &&
                             !r_key_c) begin
                    n_hit     = r_idx;
                    n_s_start = i_rd_start;
                    n_s_len   = i_rd_len;
                    if (r_seg_total >= CNT_BITS'(MAX_SEGMENTS)) begin
                        n_out.status          = ST_FULL;
                        n_out.granted_address = '0;
                        n_out.busy_count      = 7'(r_busy_total);
                        s_nx = S_DONE;
                    end else begin
                        n_idx     = r_seg_total - CNT_BITS'(1);
                        o_rd_idx  = n_idx[IDX_BITS-1:0];
                        n_rd_wait = 1'b1;
                        s_nx = S_SHIFT_UP;
                    end
                end else if (r_cmd == CMD_RELEASE && i_rd_busy && (i_rd_start + Hdr) == r_key) begin
                    n_hit     = r_idx;
                    n_s_start = i_rd_start;
                    n_s_len   = i_rd_len;
                    n_busy_total = r_busy_total - CNT_BITS'(1);
                    n_idx     = r_idx + CNT_BITS'(1);
                    o_rd_idx  = n_idx[IDX_BITS-1:0];
                    n_rd_wait = 1'b1;
                    s_nx = S_REL_NEXT;
                end else begin
                    n_idx     = r_idx + CNT_BITS'(1);
                    o_rd_idx  = n_idx[IDX_BITS-1:0];
                    n_rd_wait = 1'b1;
                    s_nx = S_SCAN;
                end
            end
            S_SHIFT_UP: begin
                // move entries above the hit up by one, top first
                if (r_idx <= r_hit) begin
                    s_nx = S_SPLIT;
                end else if (r_rd_wait) begin
                    o_rd_idx = r_idx[IDX_BITS-1:0];
                    s_nx = S_SHIFT_UP;
                end else begin
                    o_wr_en    = 1'b1;
                    o_wr_idx   = IDX_BITS'(r_idx + CNT_BITS'(1));
                    o_wr_start = i_rd_start;
                    o_wr_len   = i_rd_len;
                    o_wr_busy  = i_rd_busy;
                    n_idx      = r_idx - CNT_BITS'(1);
                    o_rd_idx   = n_idx[IDX_BITS-1:0];
                    n_rd_wait  = 1'b1;
                    s_nx = S_SHIFT_UP;
                end
            end
            S_SPLIT: begin
                if (!r_rd_wait) begin
                    // first write the free remainder
                    o_wr_en    = 1'b1;
                    o_wr_idx   = IDX_BITS'(r_hit + CNT_BITS'(1));
                    o_wr_start = r_s_start + r_key;
                    o_wr_len   = r_s_len - r_key;
                    n_rd_wait  = 1'b1;
                    s_nx = S_SPLIT;
                end else begin
                    o_wr_en    = 1'b1;
                    o_wr_idx   = r_hit[IDX_BITS-1:0];
                    o_wr_start = r_s_start;
                    o_wr_len   = r_req;
                    o_wr_busy  = 1'b1;
                    n_seg_total  = r_seg_total + CNT_BITS'(1);
                    n_busy_total = r_busy_total + CNT_BITS'(1);
                    n_out.status          = ST_OK;
                    n_out.granted_address = 24'(r_s_start + Hdr);
                    n_out.busy_count      = 7'(r_busy_total + CNT_BITS'(1));
                    s_nx = S_DONE;
                end
            end
            S_REL_NEXT: begin
                if (r_rd_wait) begin
                    o_rd_idx = r_idx[IDX_BITS-1:0];
                    s_nx = S_REL_NEXT;
                end else if (r_idx < r_seg_total && !i_rd_busy) begin
                    n_s_len = w_sum;
                    s_nx = S_MERGE_NEXT;
                end else begin
                    o_wr_en    = 1'b1;
                    o_wr_idx   = r_hit[IDX_BITS-1:0];
                    o_wr_start = r_s_start;
                    o_wr_len   = r_s_len;
                    s_nx = S_MERGE_NEXT;
                    n_idx = r_seg_total;  // marks no removal
                end
            end
            S_MERGE_NEXT: begin
                o_wr_en    = 1'b1;
                o_wr_idx   = r_hit[IDX_BITS-1:0];
                o_wr_start = r_s_start;
                o_wr_len   = r_s_len;
                if (r_idx < r_seg_total) begin
                    // remove entry hit+1
                    n_idx = r_idx;
                end
                s_nx = S_REL_PREV;
                n_rd_wait = 1'b1;
                o_rd_idx  = IDX_BITS'(r_hit - CNT_BITS'(1));
            end
            S_REL_PREV: begin
                // r_idx holds removal index or seg_total for none
                o_rd_idx = IDX_BITS'(r_hit - CNT_BITS'(1));
                if (r_rd_wait) begin
                    s_nx = S_REL_PREV;
                end else if (r_hit != '0 && !i_rd_busy) begin
                    o_wr_en    = 1'b1;
                    o_wr_idx   = IDX_BITS'(r_hit - CNT_BITS'(1));
                    o_wr_start = i_rd_start;
                    o_wr_len   = w_sum;
                    s_nx = S_MERGE_PREV;
                end else begin
                    s_nx = S_MERGE_PREV;
                    n_hit = r_seg_total;  // marks no second removal
                end
            end
            S_MERGE_PREV: begin
                // count removals: first at r_idx, then at r_hit
                if (r_idx < r_seg_total) begin
                    n_seg_total = r_seg_total - CNT_BITS'(1);
                    if (r_hit < r_seg_total) begin
                        // hit < idx, one pass moves entries from hit+2 down over both slots
                        n_idx = r_hit;
                        n_seg_total = r_seg_total - CNT_BITS'(2);
                        n_s_len = ADDR_BITS'(2);
                    end else begin
                        n_s_len = ADDR_BITS'(1);
                    end
                end else if (r_hit < r_seg_total) begin
                    n_idx = r_hit;
                    n_seg_total = r_seg_total - CNT_BITS'(1);
                    n_s_len = ADDR_BITS'(1);
                end else begin
                    n_s_len = '0;
                end
                n_rd_wait = 1'b1;
                o_rd_idx  = IDX_BITS'(n_idx + CNT_BITS'(n_s_len[1:0]));
                s_nx = (n_s_len == '0) ? S_DONE : S_SHIFT_DOWN;
                n_out.status          = ST_OK;
                n_out.granted_address = '0;
                n_out.busy_count      = 7'(r_busy_total);
            end
            S_SHIFT_DOWN: begin
                // copy entry idx+gap to idx until the new end
                o_rd_idx = IDX_BITS'(r_idx + CNT_BITS'(r_s_len[1:0]));
                if (r_idx >= r_seg_total) begin
                    s_nx = S_DONE;
                end else if (r_rd_wait) begin
                    s_nx = S_SHIFT_DOWN;
                end else begin
                    o_wr_en    = 1'b1;
                    o_wr_idx   = r_idx[IDX_BITS-1:0];
                    o_wr_start = i_rd_start;
                    o_wr_len   = i_rd_len;
                    o_wr_busy  = i_rd_busy;
                    n_idx      = r_idx + CNT_BITS'(1);
                    o_rd_idx   = IDX_BITS'(n_idx + CNT_BITS'(r_s_len[1:0]));
                    n_rd_wait  = 1'b1;
                    s_nx = S_SHIFT_DOWN;
                end
            end
            S_DONE: begin
                if (w_done_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
        n_next_state = s_nx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_seg_total  <= CNT_BITS'(1);
            r_busy_total <= '0;
            r_out_valid  <= 1'b0;
            r_rd_wait    <= 1'b0;
        end else begin
            r_state      <= n_next_state;
            r_seg_total  <= n_seg_total;
            r_busy_total <= n_busy_total;
            r_out_valid  <= n_out_valid;
            r_rd_wait    <= n_rd_wait;
        end
        r_idx     <= n_idx;
        r_hit     <= n_hit;
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_key_c   <= n_key_c;
        r_req     <= n_req;
        r_s_start <= n_s_start;
        r_s_len   <= n_s_len;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `FFHA_ASSERT_IMP(a_total_bound, i_clk, i_rst_n, 1'b1,
        r_seg_total <= CNT_BITS'(MAX_SEGMENTS) && r_seg_total != '0)
    `FFHA_ASSERT_IMP(a_busy_lt_total, i_clk, i_rst_n, 1'b1, r_busy_total < r_seg_total)
    `FFHA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && i_out_stall,
        r_out_valid && $stable(r_out))
    `FFHA_ASSERT_IMP(a_idle_only_accept, i_clk, i_rst_n, !o_in_stall, r_state == S_IDLE)

endmodule
